>>> rtl/nls_pkg.sv
// Shared types, character codes and helper functions for the number literal scanner.
package nls_pkg;

  // Longest literal in characters; the counters are 8 bits wide.
  localparam int unsigned MAX_CHARS = 255;
  localparam int unsigned CHAR_LIMIT_INT = (MAX_CHARS < 255) ? MAX_CHARS : 255;
  localparam logic [7:0] CHAR_LIMIT = CHAR_LIMIT_INT[7:0];

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_LOW_E = 8'h65;
  localparam logic [7:0] CH_UP_E  = 8'h45;
  localparam logic [7:0] CH_CARET = 8'h5E;

  typedef enum logic [2:0] {
    PH_START,
    PH_INT,
    PH_FRAC,
    PH_EXPSYM,
    PH_EXPDIG
  } phase_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_marker;
  } in_word_t;

  typedef struct packed {
    logic       valid_res;
    logic       sign_length;
    logic [7:0] integral_length;
    logic [7:0] integral_zero_run;
    logic       point_length;
    logic [7:0] fraction_length;
    logic [7:0] fraction_zero_tail;
    logic       power_symbol_length;
    logic       power_sign_length;
    logic [7:0] power_digits_length;
    logic [7:0] power_zero_run;
  } out_word_t;

  typedef struct packed {
    phase_t     phase;
    logic       failed;
    logic       zero_run_open;
    logic [7:0] char_count;
    logic       sign_seen;
    logic [7:0] int_digits;
    logic [7:0] int_zeroes;
    logic       point_seen;
    logic [7:0] frac_digits;
    logic [7:0] frac_tail;
    logic       exp_symbol;
    logic       exp_sign;
    logic [7:0] exp_digits;
    logic [7:0] exp_zeroes;
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{
    phase:         PH_START,
    failed:        1'b0,
    zero_run_open: 1'b1,
    char_count:    8'd0,
    sign_seen:     1'b0,
    int_digits:    8'd0,
    int_zeroes:    8'd0,
    point_seen:    1'b0,
    frac_digits:   8'd0,
    frac_tail:     8'd0,
    exp_symbol:    1'b0,
    exp_sign:      1'b0,
    exp_digits:    8'd0,
    exp_zeroes:    8'd0
  };

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_sign(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS);
  endfunction

  function automatic logic is_power(input logic [7:0] c);
    return (c == CH_LOW_E) || (c == CH_UP_E) || (c == CH_CARET);
  endfunction

endpackage

>>> rtl/nls_core.sv
// Scanner state register and per-character update logic for the number literal scanner.
module nls_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  nls_pkg::in_word_t  word,
  output nls_pkg::out_word_t res
);

  nls_pkg::scan_state_t st;
  nls_pkg::scan_state_t st_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= nls_pkg::SCAN_RESET;
    end else if (step) begin
      st <= st_next;
    end
  end

  // One character update; the start and exponent-symbol phases fall through
  // into the following phase when the character is not a sign.
  always_comb begin
    nls_pkg::phase_t ph;
    logic [7:0]      c;
    logic            done;
    st_next = st;
    ph      = st.phase;
    c       = word.char_byte;
    done    = 1'b0;
    if (word.end_marker) begin
      st_next = nls_pkg::SCAN_RESET;
    end else if (!st.failed) begin
      if (st.char_count >= nls_pkg::CHAR_LIMIT) begin
        st_next.failed = 1'b1;
      end else begin
        st_next.char_count = st.char_count + 8'd1;
        if (ph == nls_pkg::PH_START) begin
          ph = nls_pkg::PH_INT;
          st_next.phase = nls_pkg::PH_INT;
          if (nls_pkg::is_sign(c)) begin
            st_next.sign_seen = 1'b1;
            done = 1'b1;
          end
        end
        if (!done && ph == nls_pkg::PH_INT) begin
          done = 1'b1;
          if (nls_pkg::is_digit(c)) begin
            st_next.int_digits = st.int_digits + 8'd1;
            if (st.zero_run_open && c == nls_pkg::CH_ZERO) begin
              st_next.int_zeroes = st.int_zeroes + 8'd1;
            end else begin
              st_next.zero_run_open = 1'b0;
            end
          end else if (c == nls_pkg::CH_POINT) begin
            st_next.point_seen = 1'b1;
            st_next.phase = nls_pkg::PH_FRAC;
          end else if (nls_pkg::is_power(c)) begin
            st_next.exp_symbol = 1'b1;
            st_next.zero_run_open = 1'b1;
            st_next.phase = nls_pkg::PH_EXPSYM;
          end else begin
            st_next.failed = 1'b1;
          end
        end else if (!done && ph == nls_pkg::PH_FRAC) begin
          done = 1'b1;
          if (nls_pkg::is_digit(c)) begin
            st_next.frac_digits = st.frac_digits + 8'd1;
            if (c == nls_pkg::CH_ZERO) begin
              st_next.frac_tail = st.frac_tail + 8'd1;
            end else begin
              st_next.frac_tail = 8'd0;
            end
          end else if (nls_pkg::is_power(c)) begin
            st_next.exp_symbol = 1'b1;
            st_next.zero_run_open = 1'b1;
            st_next.phase = nls_pkg::PH_EXPSYM;
          end else begin
            st_next.failed = 1'b1;
          end
        end
        if (!done && ph == nls_pkg::PH_EXPSYM) begin
          ph = nls_pkg::PH_EXPDIG;
          st_next.phase = nls_pkg::PH_EXPDIG;
          if (nls_pkg::is_sign(c)) begin
            st_next.exp_sign = 1'b1;
            done = 1'b1;
          end
        end
        if (!done) begin
          if (ph == nls_pkg::PH_EXPDIG && nls_pkg::is_digit(c)) begin
            st_next.exp_digits = st.exp_digits + 8'd1;
            if (st.zero_run_open && c == nls_pkg::CH_ZERO) begin
              st_next.exp_zeroes = st.exp_zeroes + 8'd1;
            end else begin
              st_next.zero_run_open = 1'b0;
            end
          end else begin
            st_next.failed = 1'b1;
          end
        end
      end
    end
  end

  // Result as it would be reported if the end marker arrived now.
  always_comb begin
    logic ok;
    ok = 1'b0;
    if (st.failed || st.char_count == 8'd0) begin
      ok = 1'b0;
    end else begin
      case (st.phase)
        nls_pkg::PH_START,
        nls_pkg::PH_INT:    ok = (st.int_digits != 8'd0);
        nls_pkg::PH_FRAC:   ok = (st.int_digits != 8'd0) || (st.frac_digits != 8'd0);
        nls_pkg::PH_EXPDIG: ok = (st.exp_digits != 8'd0);
        default:            ok = 1'b0;
      endcase
    end
    res.valid_res           = ok;
    res.sign_length         = st.sign_seen;
    res.integral_length     = st.int_digits;
    res.integral_zero_run   = st.int_zeroes;
    res.point_length        = st.point_seen;
    res.fraction_length     = st.frac_digits;
    res.fraction_zero_tail  = st.frac_tail;
    res.power_symbol_length = st.exp_symbol;
    res.power_sign_length   = st.exp_sign;
    res.power_digits_length = st.exp_digits;
    res.power_zero_run      = st.exp_zeroes;
  end

`ifndef SYNTHESIS
  // An end marker returns the scanner to its start state.
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    step && word.end_marker |=> st.char_count == 8'd0 && st.phase == nls_pkg::PH_START)
    else $error("scanner state not cleared after end marker");

  // Zero runs never outgrow the digit counts they belong to.
  a_zero_runs: assert property (@(posedge clk) disable iff (rst)
    st.int_zeroes <= st.int_digits && st.frac_tail <= st.frac_digits &&
    st.exp_zeroes <= st.exp_digits)
    else $error("zero run longer than its digit span");

  // While the literal is still well formed, every character taken belongs to one span.
  a_span_sum: assert property (@(posedge clk) disable iff (rst)
    !st.failed |->
    ({2'b00, st.int_digits} + {2'b00, st.frac_digits} + {2'b00, st.exp_digits} +
     {9'd0, st.sign_seen} + {9'd0, st.point_seen} + {9'd0, st.exp_symbol} +
     {9'd0, st.exp_sign}) == {2'b00, st.char_count})
    else $error("span lengths do not add up to character count");

  // Once failed, the literal stays failed until its end marker.
  a_fail_sticks: assert property (@(posedge clk) disable iff (rst)
    st.failed && !(step && word.end_marker) |=> st.failed)
    else $error("failed flag dropped inside a literal");
`endif

endmodule

>>> rtl/number_literal_scanner_unit.sv
// Top level of the number literal scanner: input register, scanner core and result register.
// Throughput: one word per cycle in steady state, end markers included, unless a finished
// result is stuck in the result register. Each word is held in the input register until the
// core takes it and folds it into the scanner state; an end marker loads the result register
// and raises out_valid on that same edge. Reset (rst, synchronous, active high) empties both
// registers and clears the scanner.
module number_literal_scanner_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  nls_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output nls_pkg::out_word_t out_word
);

  // Input register: holds one accepted word until the core takes it.
  logic              hold_valid;
  nls_pkg::in_word_t hold_word;

  // The core may take the held word unless a finished result is stuck in the
  // result register; only then does the input side stall.
  logic advance;
  logic step;

  nls_pkg::out_word_t res;

  assign advance  = !(out_valid && out_stall);
  assign step     = hold_valid && advance;
  assign in_stall = hold_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_word <= in_word;
    end
  end

  nls_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .word (hold_word),
    .res  (res)
  );

  // Result register. A new result only loads when the previous one has been
  // taken or is being taken this cycle, because step implies advance.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && hold_word.end_marker) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && hold_word.end_marker) begin
      out_word <= res;
    end
  end

endmodule

>>> tb/number_literal_checker.sv
// Checker for the number literal scanner: tracks each literal, predicts its result word, compares.
module number_literal_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  nls_pkg::in_word_t  in_word,
  input  logic               out_valid,
  input  logic               out_stall,
  input  nls_pkg::out_word_t out_word,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    nls_pkg::phase_t stage;
    logic            broken;
    logic            lead_open;
    logic [7:0]      taken;
    logic            lit_sign;
    logic [7:0]      int_count;
    logic [7:0]      int_lead;
    logic            has_point;
    logic [7:0]      frac_count;
    logic [7:0]      frac_trail;
    logic            exp_mark;
    logic            exp_pm;
    logic [7:0]      exp_count;
    logic [7:0]      exp_lead;
  } literal_tally_t;

  localparam literal_tally_t TALLY_RESET = '{
    stage:      nls_pkg::PH_START,
    broken:     1'b0,
    lead_open:  1'b1,
    taken:      8'd0,
    lit_sign:   1'b0,
    int_count:  8'd0,
    int_lead:   8'd0,
    has_point:  1'b0,
    frac_count: 8'd0,
    frac_trail: 8'd0,
    exp_mark:   1'b0,
    exp_pm:     1'b0,
    exp_count:  8'd0,
    exp_lead:   8'd0
  };

  literal_tally_t     tally = TALLY_RESET;
  nls_pkg::out_word_t expected_results[$];
  nls_pkg::out_word_t want;
  int                 errors = 0;

  // Folds one character into the running tally of the literal.
  function automatic literal_tally_t absorb_char(literal_tally_t t, logic [7:0] c);
    literal_tally_t s;
    logic           digit;
    logic           power;
    logic           pm;
    s = t;
    digit = (c >= nls_pkg::CH_ZERO) && (c <= nls_pkg::CH_NINE);
    power = (c == nls_pkg::CH_LOW_E) || (c == nls_pkg::CH_UP_E) || (c == nls_pkg::CH_CARET);
    pm = (c == nls_pkg::CH_PLUS) || (c == nls_pkg::CH_MINUS);
    if (s.broken) return s;
    if (s.taken >= nls_pkg::CHAR_LIMIT) begin
      s.broken = 1'b1;
      return s;
    end
    s.taken = s.taken + 8'd1;
    if (s.stage == nls_pkg::PH_START) begin
      s.stage = nls_pkg::PH_INT;
      if (pm) begin
        s.lit_sign = 1'b1;
        return s;
      end
    end
    if (s.stage == nls_pkg::PH_INT) begin
      if (digit) begin
        s.int_count = s.int_count + 8'd1;
        if (s.lead_open && c == nls_pkg::CH_ZERO) s.int_lead = s.int_lead + 8'd1;
        else s.lead_open = 1'b0;
      end else if (c == nls_pkg::CH_POINT) begin
        s.has_point = 1'b1;
        s.stage = nls_pkg::PH_FRAC;
      end else if (power) begin
        s.exp_mark = 1'b1;
        s.lead_open = 1'b1;
        s.stage = nls_pkg::PH_EXPSYM;
      end else begin
        s.broken = 1'b1;
      end
      return s;
    end
    if (s.stage == nls_pkg::PH_FRAC) begin
      if (digit) begin
        s.frac_count = s.frac_count + 8'd1;
        s.frac_trail = (c == nls_pkg::CH_ZERO) ? s.frac_trail + 8'd1 : 8'd0;
      end else if (power) begin
        s.exp_mark = 1'b1;
        s.lead_open = 1'b1;
        s.stage = nls_pkg::PH_EXPSYM;
      end else begin
        s.broken = 1'b1;
      end
      return s;
    end
    if (s.stage == nls_pkg::PH_EXPSYM) begin
      s.stage = nls_pkg::PH_EXPDIG;
      if (pm) begin
        s.exp_pm = 1'b1;
        return s;
      end
    end
    if (s.stage == nls_pkg::PH_EXPDIG && digit) begin
      s.exp_count = s.exp_count + 8'd1;
      if (s.lead_open && c == nls_pkg::CH_ZERO) s.exp_lead = s.exp_lead + 8'd1;
      else s.lead_open = 1'b0;
      return s;
    end
    s.broken = 1'b1;
    return s;
  endfunction

  // Builds the result word that an end marker produces from the tally.
  function automatic nls_pkg::out_word_t close_literal(literal_tally_t t);
    nls_pkg::out_word_t r;
    logic               ok;
    if (t.broken || t.taken == 8'd0) begin
      ok = 1'b0;
    end else begin
      case (t.stage)
        nls_pkg::PH_START,
        nls_pkg::PH_INT:  ok = (t.int_count != 8'd0);
        nls_pkg::PH_FRAC: ok = (t.int_count != 8'd0) || (t.frac_count != 8'd0);
        nls_pkg::PH_EXPDIG: ok = (t.exp_count != 8'd0);
        default:          ok = 1'b0;
      endcase
    end
    r.valid_res           = ok;
    r.sign_length         = t.lit_sign;
    r.integral_length     = t.int_count;
    r.integral_zero_run   = t.int_lead;
    r.point_length        = t.has_point;
    r.fraction_length     = t.frac_count;
    r.fraction_zero_tail  = t.frac_trail;
    r.power_symbol_length = t.exp_mark;
    r.power_sign_length   = t.exp_pm;
    r.power_digits_length = t.exp_count;
    r.power_zero_run      = t.exp_lead;
    return r;
  endfunction

  function automatic int field_diff(string label, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, exp_v, act_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      tally = TALLY_RESET;
      expected_results.delete();
    end else begin
      if (in_valid && !in_stall) begin
        if (in_word.end_marker) begin
          expected_results.push_back(close_literal(tally));
          tally = TALLY_RESET;
        end else begin
          tally = absorb_char(tally, in_word.char_byte);
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result word %h arrived with none expected, expected nothing, actual %h",
                   $time, out_word, out_word);
          errors++;
        end else begin
          want = expected_results.pop_front();
          errors += field_diff("valid_res", want.valid_res, out_word.valid_res);
          errors += field_diff("sign_length", want.sign_length, out_word.sign_length);
          errors += field_diff("integral_length", want.integral_length,
                               out_word.integral_length);
          errors += field_diff("integral_zero_run", want.integral_zero_run,
                               out_word.integral_zero_run);
          errors += field_diff("point_length", want.point_length, out_word.point_length);
          errors += field_diff("fraction_length", want.fraction_length,
                               out_word.fraction_length);
          errors += field_diff("fraction_zero_tail", want.fraction_zero_tail,
                               out_word.fraction_zero_tail);
          errors += field_diff("power_symbol_length", want.power_symbol_length,
                               out_word.power_symbol_length);
          errors += field_diff("power_sign_length", want.power_sign_length,
                               out_word.power_sign_length);
          errors += field_diff("power_digits_length", want.power_digits_length,
                               out_word.power_digits_length);
          errors += field_diff("power_zero_run", want.power_zero_run, out_word.power_zero_run);
        end
      end
    end
    pending    <= expected_results.size();
    fail_count <= errors;
  end

endmodule

>>> tb/tb_number_literal_scanner_unit.sv
// Testbench top for the number literal scanner: stimulus, idling, watchdog and verdict.
module tb_number_literal_scanner_unit;

  // Cycles with no word accepted on either side before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 2000;
  // Extra cycles after the last expected result, to catch stray result words.
  localparam int DRAIN_CYCLES   = 12;
  // Words sent in each of the three idling phases.
  localparam int PHASE_WORDS    = 400;

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  nls_pkg::in_word_t  in_word = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  nls_pkg::out_word_t out_word;

  int fail_count;
  int pending;

  // Percent chance per cycle that the sender idles and the receiver stalls.
  int src_idle_pct = 0;
  int sink_stall_pct = 0;

  int         words_sent = 0;
  int         quiet = 0;
  logic [7:0] lit_chars[$];

  number_literal_scanner_unit uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  number_literal_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The receiver stalls at random; the percentage changes with each phase of the run.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < sink_stall_pct);
  end

  // Offers one word, possibly after a few idle cycles, and returns at the edge that takes it.
  // Valid stays high across back-to-back words, so it is never dropped and raised in one step.
  task automatic push_word(input nls_pkg::in_word_t w);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  // Sends the characters collected in lit_chars, then the end marker. The character
  // field of the end marker word is random since the block has to ignore it.
  task automatic send_chars();
    nls_pkg::in_word_t w;
    foreach (lit_chars[i]) begin
      w.char_byte  = lit_chars[i];
      w.end_marker = 1'b0;
      push_word(w);
    end
    w.char_byte  = 8'($urandom_range(255));
    w.end_marker = 1'b1;
    push_word(w);
  endtask

  task automatic send_text(input string s);
    lit_chars.delete();
    for (int i = 0; i < s.len(); i++) lit_chars.push_back(s[i]);
    send_chars();
  endtask

  // Zero is favored so that leading-zero and trailing-zero runs get long enough to matter.
  function automatic logic [7:0] rand_digit();
    logic [7:0] d;
    d = nls_pkg::CH_ZERO + 8'($urandom_range(9));
    if ($urandom_range(2) == 0) d = nls_pkg::CH_ZERO;
    return d;
  endfunction

  function automatic logic [7:0] rand_power();
    case ($urandom_range(2))
      0:       return nls_pkg::CH_LOW_E;
      1:       return nls_pkg::CH_UP_E;
      default: return nls_pkg::CH_CARET;
    endcase
  endfunction

  function automatic logic [7:0] rand_pm();
    return ($urandom_range(1) == 0) ? nls_pkg::CH_PLUS : nls_pkg::CH_MINUS;
  endfunction

  // A literal of n digits, the first two of them zero. With n at 255 it just fits the
  // character limit; one more character makes it overlong.
  task automatic send_digit_run(input int n);
    lit_chars.delete();
    lit_chars.push_back(nls_pkg::CH_ZERO);
    lit_chars.push_back(nls_pkg::CH_ZERO);
    for (int i = 2; i < n; i++) lit_chars.push_back(rand_digit());
    send_chars();
  endtask

  // Builds one random literal in lit_chars. Most are well formed with random content so the
  // scan reaches the fraction and exponent phases; some are damaged or pure noise.
  task automatic build_literal();
    int n_int;
    int n_frac;
    int n_exp;
    int pos;
    lit_chars.delete();
    if ($urandom_range(19) == 0) begin
      // Noise: random bytes of any value.
      n_int = $urandom_range(6);
      for (int i = 0; i < n_int; i++) lit_chars.push_back(8'($urandom_range(255)));
      return;
    end
    if ($urandom_range(2) == 0) lit_chars.push_back(rand_pm());
    // Now and then a long integral part runs into or past the character limit.
    n_int = ($urandom_range(49) == 0) ? $urandom_range(240, 262) : $urandom_range(5);
    for (int i = 0; i < n_int; i++) lit_chars.push_back(rand_digit());
    if ($urandom_range(1) == 0) begin
      lit_chars.push_back(nls_pkg::CH_POINT);
      n_frac = $urandom_range(5);
      for (int i = 0; i < n_frac; i++) lit_chars.push_back(rand_digit());
    end
    if ($urandom_range(2) == 0) begin
      lit_chars.push_back(rand_power());
      if ($urandom_range(1) == 0) lit_chars.push_back(rand_pm());
      // Zero exponent digits leaves the exponent incomplete.
      n_exp = $urandom_range(4);
      for (int i = 0; i < n_exp; i++) lit_chars.push_back(rand_digit());
    end
    if ($urandom_range(4) == 0) begin
      // Damage the literal: overwrite one character, or add a stray one at the end.
      if (lit_chars.size() != 0 && $urandom_range(1) == 0) begin
        pos = $urandom_range(lit_chars.size() - 1);
        lit_chars[pos] = 8'($urandom_range(255));
      end else begin
        case ($urandom_range(3))
          0:       lit_chars.push_back(nls_pkg::CH_POINT);
          1:       lit_chars.push_back(rand_pm());
          2:       lit_chars.push_back(rand_power());
          default: lit_chars.push_back(8'($urandom_range(255)));
        endcase
      end
    end
  endtask

  // Holds the sender back until the checker has seen every result it expects.
  task automatic wait_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Watchdog: ends the run when neither side has moved a word for too long.
  initial begin
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int phase_n = 0; phase_n < 3; phase_n++) begin
      // Receiver-heavy idling first, then sender-heavy, then full speed on both sides.
      case (phase_n)
        0: begin
          src_idle_pct   = 33;
          sink_stall_pct = 45;
        end
        1: begin
          src_idle_pct   = 45;
          sink_stall_pct = 33;
        end
        default: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
      endcase

      if (phase_n == 0) begin
        // Directed literals: empty input, plain and signed forms, a lone point or sign,
        // exponents with and without a significand, incomplete exponents, unexpected
        // characters followed by more input, and the byte extremes.
        send_text("");
        send_text("0");
        send_text("007");
        send_text("+123");
        send_text("-0.500");
        send_text(".");
        send_text("+");
        send_text("-.");
        send_text(".5");
        send_text("5.");
        send_text("1e10");
        send_text("1E-05");
        send_text("2^+3");
        send_text("e5");
        send_text("-^0");
        send_text("1e");
        send_text("1e+");
        send_text("12a3x");
        send_text("1..2");
        send_text("00.000E+0099");
        send_text("9e9e");
        lit_chars.delete();
        lit_chars.push_back(nls_pkg::CH_ZERO + 8'd1);
        lit_chars.push_back(8'h00);
        lit_chars.push_back(nls_pkg::CH_ZERO + 8'd5);
        send_chars();
        lit_chars.delete();
        lit_chars.push_back(8'hFF);
        send_chars();
        // Exactly at the character limit, and one past it.
        send_digit_run(nls_pkg::CHAR_LIMIT_INT);
        send_digit_run(nls_pkg::CHAR_LIMIT_INT + 1);
      end

      while (words_sent < (phase_n + 1) * PHASE_WORDS) begin
        build_literal();
        send_chars();
      end
      // Let the block empty completely between phases.
      wait_results();
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/nls_pkg.sv
rtl/nls_core.sv
rtl/number_literal_scanner_unit.sv
tb/number_literal_checker.sv
tb/tb_number_literal_scanner_unit.sv
